// ===== rtl/core/rmg_pkg.sv =====
// ----------------------------------------------------------------------------
// rmg_pkg
// Shared types, constants and the microcode program of the revolution mesh
// generator.
// ----------------------------------------------------------------------------
package rmg_pkg;

    localparam int MAX_PROFILE = 256;
    localparam int SWEEP_STEPS = 20;
    localparam int LEN_W       = 9;
    localparam int VC_W        = 8;
    localparam int IDX_W       = 13;
    localparam int COORD_W     = 16;
    localparam int COPY_W      = $clog2(SWEEP_STEPS);
    localparam int PC_W        = 3;

    // q1.15 cosine and sine of one sweep step
    localparam logic signed [COORD_W-1:0] COS_Q15 = 16'sd31164;
    localparam logic signed [COORD_W-1:0] SIN_Q15 = 16'sd10126;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL,
        OP_EMIT_COPY,
        OP_EMIT_CENTRE
    } op_t;

    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_IN,
        HOLD_OUT
    } hold_t;

    typedef enum logic [1:0] {
        BR_SEQ,
        BR_GOTO,
        BR_MORE,
        BR_TAIL
    } br_t;

    typedef struct packed {
        op_t              op;
        hold_t            hold_on;
        br_t              br;
        logic [PC_W-1:0]  target;
    } uword_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic step;
    } rot_ctrl_t;

    localparam logic [PC_W-1:0] PC_FETCH  = 3'd0;
    localparam logic [PC_W-1:0] PC_MUL    = 3'd1;
    localparam logic [PC_W-1:0] PC_EMIT   = 3'd2;
    localparam logic [PC_W-1:0] PC_TAIL   = 3'd3;
    localparam logic [PC_W-1:0] PC_CENTRE = 3'd4;

    // control store
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            PC_FETCH:  w = '{OP_LOAD,        HOLD_IN,   BR_SEQ,  PC_FETCH};
            PC_MUL:    w = '{OP_MUL,         HOLD_NONE, BR_SEQ,  PC_FETCH};
            PC_EMIT:   w = '{OP_EMIT_COPY,   HOLD_OUT,  BR_MORE, PC_MUL};
            PC_TAIL:   w = '{OP_NONE,        HOLD_NONE, BR_TAIL, PC_CENTRE};
            PC_CENTRE: w = '{OP_EMIT_CENTRE, HOLD_OUT,  BR_GOTO, PC_FETCH};
            default:   w = '{OP_NONE,        HOLD_NONE, BR_GOTO, PC_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/rmg_rotate.sv =====
// ----------------------------------------------------------------------------
// rmg_rotate
// Rotation unit: holds x and z, multiplies by cosine and sine, rounds and
// saturates one step of the y-axis rotation.
// ----------------------------------------------------------------------------
module rmg_rotate (
    input  logic                                   aclk,
    input  rmg_pkg::rot_ctrl_t                     ctrl,
    input  logic signed [rmg_pkg::COORD_W-1:0]     in_x,
    input  logic signed [rmg_pkg::COORD_W-1:0]     in_z,
    output logic signed [rmg_pkg::COORD_W-1:0]     nx,
    output logic signed [rmg_pkg::COORD_W-1:0]     nz
);

    logic signed [rmg_pkg::COORD_W-1:0]   x_reg, z_reg;
    logic signed [2*rmg_pkg::COORD_W-1:0] p_cx_reg, p_sz_reg, p_sx_reg, p_cz_reg;
    logic signed [2*rmg_pkg::COORD_W:0]   sum_x, sum_z;

    // add half, floor shift by 15, clamp to 16 bits
    function automatic logic signed [rmg_pkg::COORD_W-1:0] round_sat(
        input logic signed [2*rmg_pkg::COORD_W:0] s
    );
        logic signed [2*rmg_pkg::COORD_W+1:0] v;
        logic signed [2*rmg_pkg::COORD_W-14:0] q;
        logic signed [rmg_pkg::COORD_W-1:0]   r;
        v = {s[2*rmg_pkg::COORD_W], s} + 34'sd16384;
        q = v[2*rmg_pkg::COORD_W+1:15];
        if (q > 19'sd32767) begin
            r = 16'sh7FFF;
        end else if (q < -19'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = q[rmg_pkg::COORD_W-1:0];
        end
        return r;
    endfunction

    assign sum_x = {p_cx_reg[31], p_cx_reg} + {p_sz_reg[31], p_sz_reg};
    assign sum_z = {p_cz_reg[31], p_cz_reg} - {p_sx_reg[31], p_sx_reg};
    assign nx    = round_sat(sum_x);
    assign nz    = round_sat(sum_z);

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            x_reg <= in_x;
            z_reg <= in_z;
        end else if (ctrl.step) begin
            x_reg <= nx;
            z_reg <= nz;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul) begin
            p_cx_reg <= x_reg * rmg_pkg::COS_Q15;
            p_sz_reg <= z_reg * rmg_pkg::SIN_Q15;
            p_sx_reg <= x_reg * rmg_pkg::SIN_Q15;
            p_cz_reg <= z_reg * rmg_pkg::COS_Q15;
        end
    end

endmodule

// ===== rtl/core/revolution_mesh_generator_top.sv =====
// ----------------------------------------------------------------------------
// revolution_mesh_generator_top
// Sweeps profile vertices around the y axis and streams out the rotated
// vertices with their mesh indices and triangles.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tdata: x, y, z (q8.8)
//  m_       out  m_tvalid/m_tready    m_tdata: x, y, z, index, 6 corners;
//                                     m_tuser: triangle count; m_tlast
//  cfg_     in   cfg_valid/cfg_ready  cfg_data: profile length
//
//  a microcoded sequencer runs each vertex: a fetch step, then for each
//  rotated copy a multiply step and a round-and-emit step on the one
//  rotation unit, a tail step and, after the last profile vertex, a centre
//  step; the next vertex is taken only back in the fetch step.
//  reset is synchronous: the sequencer returns to fetch, profile length to 2,
//  vertex counter and first height to 0.
//  an emit step holds while the output register is full and not taken.
// ----------------------------------------------------------------------------
module revolution_mesh_generator_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input vertex transactions
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [47:0]                 s_tdata,   // in_x, in_y, in_z
    // result transactions
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [143:0]                m_tdata,   // out_x, out_y, out_z,
                                                   // vertex_index, tri_a0,
                                                   // tri_a1, tri_a2, tri_b0,
                                                   // tri_b1, tri_b2, zero pad
    output logic [1:0]                  m_tuser,   // tri_count
    output logic                        m_tlast,   // last_of_run
    // configuration write
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rmg_pkg::LEN_W-1:0]   cfg_data   // profile_len
);

    localparam int IW = rmg_pkg::IDX_W;
    localparam int CW = rmg_pkg::COORD_W;

    // sequencer
    logic [rmg_pkg::PC_W-1:0]   pc_reg, pc_next;
    rmg_pkg::uword_t            uw;
    logic                       go;
    logic                       out_free;

    // configuration and block state
    logic [rmg_pkg::LEN_W-1:0]  profile_len_reg;
    logic [rmg_pkg::LEN_W-1:0]  len_c;
    logic [rmg_pkg::VC_W-1:0]   vertex_counter_reg, vertex_counter_next;
    logic [CW-1:0]              first_height_reg;

    // per-vertex working registers
    logic [rmg_pkg::VC_W-1:0]   j_reg, j_in;
    logic                       is_last_reg, is_last_in;
    logic [CW-1:0]              y_reg;
    logic [IW-1:0]              base_reg;          // copy number times length
    logic [rmg_pkg::COPY_W-1:0] copy_reg;
    logic                       more_copies;

    // index arithmetic
    logic [IW-1:0]              len_i, centre, i_idx, k_idx;

    // rotation unit
    rmg_pkg::rot_ctrl_t         rot;
    logic signed [CW-1:0]       nx, nz;

    // output register
    logic                       m_tvalid_reg;
    logic [CW-1:0]              ox_reg, oy_reg, oz_reg;
    logic [IW-1:0]              ovi_reg, a0_reg, a1_reg, a2_reg, b0_reg, b1_reg, b2_reg;
    logic [1:0]                 ocnt_reg;
    logic                       olast_reg;

    // ------------------------------------------------------------------
    // length clamp and derived indices
    // ------------------------------------------------------------------
    always_comb begin
        if (profile_len_reg < 9'd2) begin
            len_c = 9'd2;
        end else if (profile_len_reg > 9'(rmg_pkg::MAX_PROFILE)) begin
            len_c = 9'(rmg_pkg::MAX_PROFILE);
        end else begin
            len_c = profile_len_reg;
        end
    end

    assign len_i  = IW'(len_c);
    // centre vertex sits after all copies
    assign centre = IW'(len_i * IW'(rmg_pkg::SWEEP_STEPS + 1));
    assign i_idx  = base_reg + IW'(j_reg);
    assign k_idx  = i_idx + len_i;

    // position of the incoming vertex, past-the-end counts as last
    assign is_last_in = ({1'b0, vertex_counter_reg} >= (len_c - 9'd1));
    assign j_in       = is_last_in ? rmg_pkg::VC_W'(len_c - 9'd1) : vertex_counter_reg;
    assign vertex_counter_next = is_last_in ? '0 : j_in + 8'd1;

    assign more_copies = (copy_reg != rmg_pkg::COPY_W'(rmg_pkg::SWEEP_STEPS - 1));

    // ------------------------------------------------------------------
    // sequencer: control word fetch, hold condition, next step
    // ------------------------------------------------------------------
    assign uw       = rmg_pkg::ucode(pc_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        unique case (uw.hold_on)
            rmg_pkg::HOLD_NONE: go = 1'b1;
            rmg_pkg::HOLD_IN:   go = s_tvalid;
            rmg_pkg::HOLD_OUT:  go = out_free;
            default:            go = 1'b0;
        endcase
    end

    always_comb begin
        pc_next = pc_reg;
        if (go) begin
            unique case (uw.br)
                rmg_pkg::BR_SEQ:  pc_next = pc_reg + 3'd1;
                rmg_pkg::BR_GOTO: pc_next = uw.target;
                rmg_pkg::BR_MORE: pc_next = more_copies ? uw.target : pc_reg + 3'd1;
                rmg_pkg::BR_TAIL: pc_next = is_last_reg ? uw.target : rmg_pkg::PC_FETCH;
                default:          pc_next = rmg_pkg::PC_FETCH;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= rmg_pkg::PC_FETCH;
        end else begin
            pc_reg <= pc_next;
        end
    end

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign s_tready  = (uw.hold_on == rmg_pkg::HOLD_IN);
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // configuration and vertex state
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            profile_len_reg    <= 9'd2;
            vertex_counter_reg <= '0;
            first_height_reg   <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                profile_len_reg <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                vertex_counter_reg <= vertex_counter_next;
                if (j_in == '0) begin
                    first_height_reg <= s_tdata[31:16];
                end
            end
        end
    end

    // working registers for the vertex being swept
    always_ff @(posedge aclk) begin
        if (uw.op == rmg_pkg::OP_LOAD && go) begin
            j_reg       <= j_in;
            is_last_reg <= is_last_in;
            y_reg       <= s_tdata[31:16];
            base_reg    <= '0;
            copy_reg    <= '0;
        end else if (uw.op == rmg_pkg::OP_EMIT_COPY && go) begin
            base_reg <= base_reg + len_i;
            copy_reg <= copy_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // rotation unit
    // ------------------------------------------------------------------
    assign rot.load = (uw.op == rmg_pkg::OP_LOAD) && go;
    assign rot.mul  = (uw.op == rmg_pkg::OP_MUL);
    assign rot.step = (uw.op == rmg_pkg::OP_EMIT_COPY) && go;

    rmg_rotate u_rotate (
        .aclk (aclk),
        .ctrl (rot),
        .in_x (s_tdata[15:0]),
        .in_z (s_tdata[47:32]),
        .nx   (nx),
        .nz   (nz)
    );

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((uw.op == rmg_pkg::OP_EMIT_COPY || uw.op == rmg_pkg::OP_EMIT_CENTRE)
                     && go) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (uw.op == rmg_pkg::OP_EMIT_COPY && go) begin
            ox_reg  <= nx;
            oy_reg  <= y_reg;
            oz_reg  <= nz;
            ovi_reg <= k_idx;
            if (j_reg == '0) begin
                // bottom cap toward the centre vertex
                a0_reg   <= centre;
                a1_reg   <= base_reg + len_i;
                a2_reg   <= base_reg;
                b0_reg   <= '0;
                b1_reg   <= '0;
                b2_reg   <= '0;
                ocnt_reg <= 2'd1;
            end else begin
                // two side triangles toward the previous profile vertex
                a0_reg   <= i_idx - 13'd1;
                a1_reg   <= k_idx - 13'd1;
                a2_reg   <= k_idx;
                b0_reg   <= i_idx - 13'd1;
                b1_reg   <= k_idx;
                b2_reg   <= i_idx;
                ocnt_reg <= 2'd2;
            end
            olast_reg <= !more_copies && !is_last_reg;
        end else if (uw.op == rmg_pkg::OP_EMIT_CENTRE && go) begin
            ox_reg    <= '0;
            oy_reg    <= first_height_reg;
            oz_reg    <= '0;
            ovi_reg   <= centre;
            a0_reg    <= '0;
            a1_reg    <= '0;
            a2_reg    <= '0;
            b0_reg    <= '0;
            b1_reg    <= '0;
            b2_reg    <= '0;
            ocnt_reg  <= 2'd0;
            olast_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, b2_reg, b1_reg, b0_reg, a2_reg, a1_reg, a0_reg,
                       ovi_reg, oz_reg, oy_reg, ox_reg};
    assign m_tuser  = ocnt_reg;
    assign m_tlast  = olast_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // one vertex at a time: no new input right after an accepted one
    a_one_vertex: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a vertex is in flight");

    // copy counter stays within the sweep while copies are emitted
    a_copy_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (uw.op == rmg_pkg::OP_EMIT_COPY) |->
            (copy_reg <= rmg_pkg::COPY_W'(rmg_pkg::SWEEP_STEPS - 1)))
        else $error("copy counter past the sweep");

    // centre vertex only follows the last profile vertex
    a_centre_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (uw.op == rmg_pkg::OP_EMIT_CENTRE) |-> is_last_reg)
        else $error("centre emitted for a vertex that is not last");

    // a waiting result transaction holds steady until it is taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("result changed while waiting");

endmodule
